>>> sv/mcr_pkg.sv
// shared constants for the midpoint circle rasterizer
package mcr_pkg;

    // default coordinate width of center and radius
    localparam int COORD_WIDTH = 10;

    // packed rgb color width
    localparam int COLOR_WIDTH = 24;

    // records held between the step unit and the point emitter
    localparam int QUEUE_DEPTH = 2;

    // points emitted per step
    localparam int POINTS_PER_STEP = 8;

    // item opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

endpackage

>>> sv/mcr_front.sv
// step unit: takes items, runs the midpoint rule and queues one record per step
module mcr_front #(
    parameter int CW = mcr_pkg::COORD_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              opcode,
    input  logic [CW-1:0]     center_x,
    input  logic [CW-1:0]     center_y,
    input  logic [CW-1:0]     radius,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [4*CW:0]     push_data
);

    localparam int DW = CW + 3;

    logic [CW-1:0] hold_cx_reg, hold_cx_next;
    logic [CW-1:0] hold_cy_reg, hold_cy_next;
    logic [CW-1:0] step_x_reg, step_x_next;
    logic [CW-1:0] step_y_reg, step_y_next;
    logic [DW-1:0] decision_reg, decision_next;
    logic          active_reg, active_next;

    logic          is_start;
    logic          accept;
    logic          step_done;
    logic [DW-1:0] x_ext;
    logic [DW-1:0] y_ext;
    logic [DW-1:0] dec_keep;
    logic [DW-1:0] dec_diag;

    // an item is taken whenever the queue has room
    assign item_ready = push_ready;
    assign accept     = item_valid && item_ready;
    assign is_start   = (opcode == mcr_pkg::OP_START);

    // an advance with no circle in progress produces no record
    assign push_valid = item_valid && (is_start || active_reg);

    // midpoint decision candidates, modulo the decision width
    assign x_ext    = DW'(step_x_reg);
    assign y_ext    = DW'(step_y_reg);
    assign dec_keep = decision_reg + (x_ext << 1) + DW'(3);
    assign dec_diag = decision_reg + ((x_ext - y_ext) << 1) + DW'(5);

    // next state of the circle walk
    always_comb
    begin
        hold_cx_next  = hold_cx_reg;
        hold_cy_next  = hold_cy_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        if (is_start)
        begin
            hold_cx_next  = center_x;
            hold_cy_next  = center_y;
            step_x_next   = '0;
            step_y_next   = radius;
            decision_next = DW'(1) - DW'(radius);
        end
        else if (decision_reg[DW-1])
        begin
            step_x_next   = step_x_reg + CW'(1);
            decision_next = dec_keep;
        end
        else
        begin
            step_x_next   = step_x_reg + CW'(1);
            step_y_next   = step_y_reg - CW'(1);
            decision_next = dec_diag;
        end
        step_done = !(step_y_next > step_x_next);
        if (is_start || active_reg)
        begin
            active_next = !step_done;
        end
    end

    // record of the step: done flag, center, offsets
    assign push_data = {step_done, hold_cx_next, hold_cy_next, step_x_next, step_y_next};

    // state update on each transfer that carries a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cx_reg  <= '0;
            hold_cy_reg  <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end
        else if (accept && push_valid)
        begin
            hold_cx_reg  <= hold_cx_next;
            hold_cy_reg  <= hold_cy_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

endmodule

>>> sv/mcr_queue.sv
// small fifo of step records between the step unit and the emitter
module mcr_queue #(
    parameter int WIDTH = 4 * mcr_pkg::COORD_WIDTH + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = mcr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/mcr_back.sv
// point emitter: expands each step record into eight symmetric points
module mcr_back #(
    parameter int CW = mcr_pkg::COORD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mcr_pkg::COLOR_WIDTH-1:0]     cfg_wdata,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  logic [4*CW:0]                       pop_data,
    output logic                                point_valid,
    input  logic                                point_ready,
    output logic signed [CW+1:0]                pixel_x,
    output logic signed [CW+1:0]                pixel_y,
    output logic [mcr_pkg::COLOR_WIDTH-1:0]     color,
    output logic                                last,
    output logic                                circle_done
);

    localparam int OW = CW + 2;
    localparam int IW = $clog2(mcr_pkg::POINTS_PER_STEP);
    localparam logic [IW-1:0] LAST_IDX = IW'(mcr_pkg::POINTS_PER_STEP - 1);

    logic [mcr_pkg::COLOR_WIDTH-1:0] draw_color_reg;
    logic [4*CW:0]                   rec_reg;
    logic                            rec_valid_reg, rec_valid_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic                            point_valid_reg, point_valid_next;
    logic signed [OW-1:0]            pixel_x_reg;
    logic signed [OW-1:0]            pixel_y_reg;
    logic [mcr_pkg::COLOR_WIDTH-1:0] color_reg;
    logic                            last_reg;
    logic                            done_reg;

    logic                            emit;
    logic                            emit_last;
    logic [OW-1:0]                   cx_e, cy_e, x_e, y_e;
    logic [OW-1:0]                   px, py;

    // color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            draw_color_reg <= cfg_wdata;
        end
    end

    // emit one point whenever a record is held and the output register is free or drains
    assign emit      = rec_valid_reg && (!point_valid_reg || point_ready);
    assign emit_last = emit && (idx_reg == LAST_IDX);
    assign pop_ready = !rec_valid_reg || emit_last;

    // record fields widened to the output width
    assign cx_e = OW'(rec_reg[4*CW-1:3*CW]);
    assign cy_e = OW'(rec_reg[3*CW-1:2*CW]);
    assign x_e  = OW'(rec_reg[2*CW-1:CW]);
    assign y_e  = OW'(rec_reg[CW-1:0]);

    // symmetric point for the current index
    always_comb
    begin
        unique case (idx_reg)
            3'd0:
            begin
                px = cx_e + x_e;
                py = cy_e + y_e;
            end
            3'd1:
            begin
                px = cx_e + x_e;
                py = cy_e - y_e;
            end
            3'd2:
            begin
                px = cx_e + y_e;
                py = cy_e + x_e;
            end
            3'd3:
            begin
                px = cx_e + y_e;
                py = cy_e - x_e;
            end
            3'd4:
            begin
                px = cx_e - x_e;
                py = cy_e - y_e;
            end
            3'd5:
            begin
                px = cx_e - y_e;
                py = cy_e - x_e;
            end
            3'd6:
            begin
                px = cx_e - x_e;
                py = cy_e + y_e;
            end
            3'd7:
            begin
                px = cx_e - y_e;
                py = cy_e + x_e;
            end
        endcase
    end

    // control of the current record and the output stage
    always_comb
    begin
        rec_valid_next   = rec_valid_reg;
        idx_next         = idx_reg;
        point_valid_next = point_valid_reg;
        if (emit)
        begin
            idx_next         = idx_reg + IW'(1);
            point_valid_next = 1'b1;
        end
        else if (point_ready)
        begin
            point_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready)
        begin
            rec_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (emit_last)
        begin
            rec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg   <= rec_valid_next;
            idx_reg         <= idx_next;
            point_valid_reg <= point_valid_next;
        end
    end

    // record load
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            rec_reg <= pop_data;
        end
    end

    // output payload load
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg <= px;
            pixel_y_reg <= py;
            color_reg   <= draw_color_reg;
            last_reg    <= (idx_reg == LAST_IDX);
            done_reg    <= rec_reg[4*CW];
        end
    end

    assign point_valid = point_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign color       = color_reg;
    assign last        = last_reg;
    assign circle_done = done_reg;

endmodule

>>> sv/midpoint_circle_rasterizer.sv
// top level of the midpoint circle rasterizer
//
// Items come in on item_valid / item_ready with opcode, center_x, center_y
// and radius. A start item loads a new circle; an advance item takes one
// midpoint step. Each step that produces output gives eight points on
// point_valid / point_ready, one per transfer, with last on the eighth and
// circle_done on all eight points of the step that finishes the circle.
// An advance with no circle in progress is taken and gives nothing.
// cfg_we / cfg_wdata write the drawing color.
// After its item transfer, the first point of a step passes through the
// queue entry, the record register and the output register before it is
// shown on point_valid.
// Throughput: one point per cycle while the receiver is ready, set by the
// single point port. The step unit takes an item in every cycle while
// its two-entry record queue has room, so items run ahead of the emitter.
// When the receiver stalls, the output register holds its point, the
// emitter stops and the queue fills, after which item_ready drops.
// Reset clears the circle state, the queue, the emitter and the color.
module midpoint_circle_rasterizer #(
    parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mcr_pkg::COLOR_WIDTH-1:0]     cfg_wdata,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                opcode,
    input  logic [COORD_WIDTH-1:0]              center_x,
    input  logic [COORD_WIDTH-1:0]              center_y,
    input  logic [COORD_WIDTH-1:0]              radius,
    output logic                                point_valid,
    input  logic                                point_ready,
    output logic signed [COORD_WIDTH+1:0]       pixel_x,
    output logic signed [COORD_WIDTH+1:0]       pixel_y,
    output logic [mcr_pkg::COLOR_WIDTH-1:0]     color,
    output logic                                last,
    output logic                                circle_done
);

    localparam int REC_W = 4 * COORD_WIDTH + 1;

    logic             push_valid;
    logic             push_ready;
    logic [REC_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [REC_W-1:0] pop_data;

    // step unit
    mcr_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .opcode     (opcode),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // record queue
    mcr_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // point emitter
    mcr_back #(
        .CW (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color       (color),
        .last        (last),
        .circle_done (circle_done)
    );

endmodule
